### rtl/ppu_pkg.sv
// Package for the partial permutation unrank core.
// Holds field widths, register indexes, the item shape and the back-end state type.
`timescale 1ns / 1ps

package ppu_pkg;

   localparam int CFG_W      = 5;
   localparam int OUT_W      = 4;
   localparam int CSR_IDX_W  = 2;
   localparam int DIGIT_BITS = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_DOMAIN_SIZE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CHOOSE_COUNT = 2'd1;

   localparam logic [CFG_W-1:0] DOMAIN_RESET = 5'd16;
   localparam logic [CFG_W-1:0] COUNT_RESET  = 5'd16;

   // Effective domain size and position count of one item, after clamping
   typedef struct packed {
      logic [CFG_W-1:0] dom;
      logic [CFG_W-1:0] cnt;
   } shape_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_START,
      ST_DIV,
      ST_EMIT
   } back_state_type;

endpackage

### rtl/ppu_front.sv
// Front end: configuration registers, clamping of the item shape and a two-entry queue.
// Depends on ppu_pkg.
`timescale 1ns / 1ps

module ppu_front import ppu_pkg::*; #(
   parameter int MAX_DOMAIN = 16,
   parameter int RANK_BITS  = 45
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [RANK_BITS-1:0] req_rank,
   output logic                 item_valid,
   input  logic                 item_pop,
   output logic [RANK_BITS-1:0] item_rank,
   output shape_type            item_shape
);

   localparam logic [CFG_W:0]   MAX_DOM_WIDE = (CFG_W+1)'(MAX_DOMAIN);
   localparam logic [CFG_W-1:0] MAX_DOM_CFG  = CFG_W'(MAX_DOMAIN);

   logic [CFG_W-1:0]     dom_cfg_ff, dom_cfg_in;
   logic [CFG_W-1:0]     cnt_cfg_ff, cnt_cfg_in;
   logic [RANK_BITS-1:0] q_rank_ff [2];
   logic [RANK_BITS-1:0] q_rank_in [2];
   shape_type            q_shape_ff [2];
   shape_type            q_shape_in [2];
   logic                 wr_ptr_ff, wr_ptr_in;
   logic                 rd_ptr_ff, rd_ptr_in;
   logic [1:0]           q_cnt_ff, q_cnt_in;
   logic                 push;
   shape_type            shape;

   always_comb begin
      dom_cfg_in = dom_cfg_ff;
      cnt_cfg_in = cnt_cfg_ff;
      if (csr_write_en && csr_index == CSR_DOMAIN_SIZE) begin
         dom_cfg_in = csr_wdata;
      end
      if (csr_write_en && csr_index == CSR_CHOOSE_COUNT) begin
         cnt_cfg_in = csr_wdata;
      end
   end

   // Clamp domain to 1..MAX_DOMAIN, then count to 1..domain
   always_comb begin
      shape.dom = dom_cfg_ff;
      if (dom_cfg_ff == '0) begin
         shape.dom = CFG_W'(1);
      end else if ({1'b0, dom_cfg_ff} > MAX_DOM_WIDE) begin
         shape.dom = MAX_DOM_CFG;
      end
      shape.cnt = cnt_cfg_ff;
      if (cnt_cfg_ff == '0) begin
         shape.cnt = CFG_W'(1);
      end else if (cnt_cfg_ff > shape.dom) begin
         shape.cnt = shape.dom;
      end
   end

   assign req_ready  = (q_cnt_ff != 2'd2);
   assign push       = req_valid && req_ready;
   assign item_valid = (q_cnt_ff != 2'd0);
   assign item_rank  = q_rank_ff[rd_ptr_ff];
   assign item_shape = q_shape_ff[rd_ptr_ff];

   always_comb begin
      q_rank_in  = q_rank_ff;
      q_shape_in = q_shape_ff;
      wr_ptr_in  = wr_ptr_ff;
      rd_ptr_in  = rd_ptr_ff;
      q_cnt_in   = q_cnt_ff;
      if (push) begin
         q_rank_in[wr_ptr_ff]  = req_rank;
         q_shape_in[wr_ptr_ff] = shape;
         wr_ptr_in             = ~wr_ptr_ff;
      end
      if (item_pop) begin
         rd_ptr_in = ~rd_ptr_ff;
      end
      if (push && !item_pop) begin
         q_cnt_in = q_cnt_ff + 2'd1;
      end else if (!push && item_pop) begin
         q_cnt_in = q_cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dom_cfg_ff <= DOMAIN_RESET;
         cnt_cfg_ff <= COUNT_RESET;
         wr_ptr_ff  <= 1'b0;
         rd_ptr_ff  <= 1'b0;
         q_cnt_ff   <= 2'd0;
      end else begin
         dom_cfg_ff <= dom_cfg_in;
         cnt_cfg_ff <= cnt_cfg_in;
         wr_ptr_ff  <= wr_ptr_in;
         rd_ptr_ff  <= rd_ptr_in;
         q_cnt_ff   <= q_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      q_rank_ff  <= q_rank_in;
      q_shape_ff <= q_shape_in;
   end

   a_pop_needs_entry: assert property (@(posedge clock) disable iff (reset)
      item_pop |-> q_cnt_ff != 2'd0)
      else $error("queue popped while empty");

endmodule

### rtl/ppu_div.sv
// Iterative divider of the remaining rank by a small radix, eight quotient bits a cycle.
// Depends on ppu_pkg.
`timescale 1ns / 1ps

module ppu_div import ppu_pkg::*; #(
   parameter int MAX_DOMAIN = 16,
   parameter int RANK_BITS  = 45
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [RANK_BITS-1:0]               dividend,
   input  logic [$clog2(MAX_DOMAIN+1)-1:0]    radix,
   output logic                               done,
   output logic [RANK_BITS-1:0]               quotient,
   output logic [$clog2(MAX_DOMAIN+1)-1:0]    remainder
);

   localparam int RADIX_W   = $clog2(MAX_DOMAIN+1);
   localparam int DIV_STEPS = (RANK_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
   localparam int PAD_W     = DIV_STEPS * DIGIT_BITS;
   localparam int STEP_W    = $clog2(DIV_STEPS+1);

   logic [PAD_W-1:0]      acc_ff, acc_in;
   logic [RADIX_W-1:0]    rem_ff, rem_in;
   logic [RADIX_W-1:0]    radix_ff, radix_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic                  done_ff, done_in;
   logic [RADIX_W:0]      trial;
   logic [RADIX_W-1:0]    part;
   logic [DIGIT_BITS-1:0] qbits;

   // Eight restoring steps on the top byte of the shifting dividend
   always_comb begin
      part  = rem_ff;
      qbits = '0;
      trial = '0;
      for (int k = 0; k < DIGIT_BITS; k++) begin
         trial = {part, acc_ff[PAD_W-1-k]};
         if (trial >= {1'b0, radix_ff}) begin
            trial                  = trial - {1'b0, radix_ff};
            qbits[DIGIT_BITS-1-k] = 1'b1;
         end
         part = trial[RADIX_W-1:0];
      end
   end

   always_comb begin
      acc_in   = acc_ff;
      rem_in   = rem_ff;
      radix_in = radix_ff;
      step_in  = step_ff;
      done_in  = 1'b0;
      if (start) begin
         acc_in   = PAD_W'(dividend);
         rem_in   = '0;
         radix_in = radix;
         step_in  = STEP_W'(DIV_STEPS);
      end else if (step_ff != '0) begin
         acc_in  = (acc_ff << DIGIT_BITS) | PAD_W'(qbits);
         rem_in  = part;
         step_in = step_ff - STEP_W'(1);
         done_in = (step_ff == STEP_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff   <= acc_in;
      rem_ff   <= rem_in;
      radix_ff <= radix_in;
   end

   assign done      = done_ff;
   assign quotient  = acc_ff[RANK_BITS-1:0];
   assign remainder = rem_ff;

   a_rem_below_radix: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> rem_ff < radix_ff)
      else $error("remainder not below radix");

   a_start_when_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> step_ff == '0)
      else $error("division started while busy");

endmodule

### rtl/ppu_back.sv
// Back end: digit sequencer, shifting selection window and result register.
// Depends on ppu_pkg; drives one ppu_div instance through its start and done.
`timescale 1ns / 1ps

module ppu_back import ppu_pkg::*; #(
   parameter int MAX_DOMAIN = 16,
   parameter int RANK_BITS  = 45
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            item_valid,
   output logic                            item_pop,
   input  logic [RANK_BITS-1:0]            item_rank,
   input  shape_type                       item_shape,
   output logic                            div_start,
   output logic [RANK_BITS-1:0]            div_dividend,
   output logic [$clog2(MAX_DOMAIN+1)-1:0] div_radix,
   input  logic                            div_done,
   input  logic [RANK_BITS-1:0]            div_quotient,
   input  logic [$clog2(MAX_DOMAIN+1)-1:0] div_remainder,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [OUT_W-1:0]                rsp_position,
   output logic [OUT_W-1:0]                rsp_mapped_value,
   output logic                            rsp_last
);

   localparam int RADIX_W = $clog2(MAX_DOMAIN+1);
   localparam int IDX_W   = $clog2(MAX_DOMAIN);

   back_state_type       state_ff, state_in;
   logic [RANK_BITS-1:0] rem_ff, rem_in;
   shape_type            shape_ff, shape_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [IDX_W-1:0]     win_ff [MAX_DOMAIN];
   logic [IDX_W-1:0]     win_in [MAX_DOMAIN];
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0]     pos_ff, pos_in;
   logic [OUT_W-1:0]     val_ff, val_in;
   logic                 last_ff, last_in;
   logic                 out_free;
   logic                 advance;
   logic                 last_pos;
   logic [IDX_W-1:0]     digit;
   logic [IDX_W-1:0]     picked;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign last_pos = (CFG_W'(idx_ff) + CFG_W'(1)) == shape_ff.cnt;
   assign digit    = div_remainder[IDX_W-1:0];
   assign picked   = win_ff[digit];

   assign div_dividend = rem_ff;
   assign div_radix    = RADIX_W'(shape_ff.dom - CFG_W'(idx_ff));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (item_valid) state_in = ST_START;
         end
         ST_START: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) state_in = last_pos ? ST_IDLE : ST_START;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      item_pop  = 1'b0;
      div_start = 1'b0;
      advance   = 1'b0;
      unique case (state_ff)
         ST_IDLE:  item_pop  = item_valid;
         ST_START: div_start = 1'b1;
         ST_DIV:   ;
         ST_EMIT:  advance   = out_free;
         default:  ;
      endcase
   end

   // Window holds the scratch entries from the current position upward.
   // Take entry digit, put the head in its place, then drop the head.
   always_comb begin
      rem_in       = rem_ff;
      shape_in     = shape_ff;
      idx_in       = idx_ff;
      win_in       = win_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      pos_in       = pos_ff;
      val_in       = val_ff;
      last_in      = last_ff;
      if (item_pop) begin
         rem_in   = item_rank;
         shape_in = item_shape;
         idx_in   = '0;
         for (int k = 0; k < MAX_DOMAIN; k++) begin
            win_in[k] = IDX_W'(k);
         end
      end
      if (advance) begin
         rem_in = div_quotient;
         idx_in = idx_ff + IDX_W'(1);
         for (int k = 0; k < MAX_DOMAIN - 1; k++) begin
            win_in[k] = (IDX_W'(k + 1) == digit) ? win_ff[0] : win_ff[k+1];
         end
         rsp_valid_in = 1'b1;
         pos_in       = OUT_W'(idx_ff);
         val_in       = OUT_W'(picked);
         last_in      = last_pos;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      shape_ff <= shape_in;
      idx_ff   <= idx_in;
      win_ff   <= win_in;
      pos_ff   <= pos_in;
      val_ff   <= val_in;
      last_ff  <= last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_position     = pos_ff;
   assign rsp_mapped_value = val_ff;
   assign rsp_last         = last_ff;

   a_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV)
      else $error("division finished outside the wait state");

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> CFG_W'(idx_ff) < shape_ff.cnt)
      else $error("position beyond count");

   a_value_in_domain: assert property (@(posedge clock) disable iff (reset)
      advance |-> CFG_W'(picked) < shape_ff.dom)
      else $error("mapped value outside domain");

endmodule

### rtl/partial_permutation_unrank_core.sv
// The first result follows the rank transfer through the queue, the back-end start state,
// the divider and the emit state. The back end works on one rank at a time and takes no
// new rank until it has emitted the results for all n positions, n being the clamped count.
// A two-entry queue lets the front take further ranks while the back end works.
// Reset (synchronous, active high) empties the queue and result register and loads
// domain_size = 16, choose_count = 16. Depends on ppu_pkg, ppu_front, ppu_div, ppu_back.
`timescale 1ns / 1ps

module partial_permutation_unrank_core import ppu_pkg::*; #(
   parameter int MAX_DOMAIN = 16,
   parameter int RANK_BITS  = 45
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [RANK_BITS-1:0] req_rank,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [OUT_W-1:0]     rsp_position,
   output logic [OUT_W-1:0]     rsp_mapped_value,
   output logic                 rsp_last
);

   localparam int RADIX_W = $clog2(MAX_DOMAIN+1);

   logic                 item_valid;
   logic                 item_pop;
   logic [RANK_BITS-1:0] item_rank;
   shape_type            item_shape;
   logic                 div_start;
   logic [RANK_BITS-1:0] div_dividend;
   logic [RADIX_W-1:0]   div_radix;
   logic                 div_done;
   logic [RANK_BITS-1:0] div_quotient;
   logic [RADIX_W-1:0]   div_remainder;

   ppu_front #(
      .MAX_DOMAIN (MAX_DOMAIN),
      .RANK_BITS  (RANK_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_rank     (req_rank),
      .item_valid   (item_valid),
      .item_pop     (item_pop),
      .item_rank    (item_rank),
      .item_shape   (item_shape)
   );

   ppu_div #(
      .MAX_DOMAIN (MAX_DOMAIN),
      .RANK_BITS  (RANK_BITS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .radix     (div_radix),
      .done      (div_done),
      .quotient  (div_quotient),
      .remainder (div_remainder)
   );

   ppu_back #(
      .MAX_DOMAIN (MAX_DOMAIN),
      .RANK_BITS  (RANK_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .item_valid       (item_valid),
      .item_pop         (item_pop),
      .item_rank        (item_rank),
      .item_shape       (item_shape),
      .div_start        (div_start),
      .div_dividend     (div_dividend),
      .div_radix        (div_radix),
      .div_done         (div_done),
      .div_quotient     (div_quotient),
      .div_remainder    (div_remainder),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_position     (rsp_position),
      .rsp_mapped_value (rsp_mapped_value),
      .rsp_last         (rsp_last)
   );

endmodule
